FILE: rtl/core/bse_pkg.sv
// Shared types and read-address select codes for the bubble sort engine.
package bse_pkg;

  // Read-address select for the element store.
  typedef logic [1:0] rd_sel_t;
  localparam rd_sel_t RD_ZERO = 2'd0;
  localparam rd_sel_t RD_K1   = 2'd1;
  localparam rd_sel_t RD_K2   = 2'd2;
  localparam rd_sel_t RD_J    = 2'd3;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic    store_in;   // an input request is accepted this cycle
    logic    sort_init;  // set up the pass bound and the output index
    logic    ld_cur;     // load the carried element from the store
    logic    step;       // compare carried element with its right neighbor
    logic    pass_end;   // write the carried element at the end of the pass
    logic    out_load;   // capture one sorted element for the output
    logic    out_next;   // advance the output index
    logic    run_done;   // clear count and overflow flag after the run
    rd_sel_t rd_sel;
  } bse_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic count_gt1;  // more than one element stored
    logic step_last;  // this compare is the last one of the pass
    logic hi_one;     // the pass that ends now was the final one
    logic j_last;     // output index points at the final element
  } bse_stat_t;

endpackage

FILE: rtl/core/bse_ctrl.sv
// Controller state machine: collect, sort passes and output sequencing.
module bse_ctrl
  import bse_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_tvalid,
  input  logic      in_tlast,
  output logic      in_tready,
  input  logic      out_tready,
  output logic      out_tvalid,
  input  bse_stat_t stat,
  output bse_cmd_t  cmd
);

  localparam logic [2:0] ST_IDLE     = 3'd0;
  localparam logic [2:0] ST_INIT     = 3'd1;
  localparam logic [2:0] ST_PASS_LD  = 3'd2;
  localparam logic [2:0] ST_STEP     = 3'd3;
  localparam logic [2:0] ST_PASS_END = 3'd4;
  localparam logic [2:0] ST_OUT_RD   = 3'd5;
  localparam logic [2:0] ST_OUT_LOAD = 3'd6;
  localparam logic [2:0] ST_OUT_WAIT = 3'd7;

  logic [2:0] state_r;
  logic [2:0] state_nxt;
  logic       in_acc;
  logic       out_acc;

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = (state_r == ST_OUT_WAIT);
  assign in_acc     = in_tvalid & in_tready;
  assign out_acc    = out_tvalid & out_tready;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    cmd.rd_sel = RD_ZERO;
    unique case (state_r)
      ST_IDLE: begin
        cmd.store_in = in_acc;
        if (in_acc && in_tlast) begin
          state_nxt = ST_INIT;
        end
      end
      ST_INIT: begin
        cmd.sort_init = 1'b1;
        cmd.rd_sel    = RD_ZERO;
        state_nxt     = stat.count_gt1 ? ST_PASS_LD : ST_OUT_RD;
      end
      ST_PASS_LD: begin
        cmd.ld_cur = 1'b1;
        cmd.rd_sel = RD_K1;
        state_nxt  = ST_STEP;
      end
      ST_STEP: begin
        cmd.step   = 1'b1;
        cmd.rd_sel = RD_K2;
        if (stat.step_last) begin
          state_nxt = ST_PASS_END;
        end
      end
      ST_PASS_END: begin
        cmd.pass_end = 1'b1;
        cmd.rd_sel   = RD_ZERO;
        state_nxt    = stat.hi_one ? ST_OUT_RD : ST_PASS_LD;
      end
      ST_OUT_RD: begin
        cmd.rd_sel = RD_J;
        state_nxt  = ST_OUT_LOAD;
      end
      ST_OUT_LOAD: begin
        cmd.out_load = 1'b1;
        state_nxt    = ST_OUT_WAIT;
      end
      ST_OUT_WAIT: begin
        if (out_acc) begin
          if (stat.j_last) begin
            cmd.run_done = 1'b1;
            state_nxt    = ST_IDLE;
          end else begin
            cmd.out_next = 1'b1;
            state_nxt    = ST_OUT_RD;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

FILE: rtl/core/bse_dp.sv
// Datapath: element store, carried-element compare, counters and output register.
module bse_dp
  import bse_pkg::*;
#(
  parameter int MAX_ELEMENTS = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  bse_cmd_t    cmd,
  input  logic [31:0] in_value,
  output bse_stat_t   stat,
  output logic [31:0] out_value,
  output logic        out_last,
  output logic        out_dropped
);

  localparam int AW = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;
  localparam int CW = $clog2(MAX_ELEMENTS + 1);

  logic [31:0]   mem [MAX_ELEMENTS];
  logic [31:0]   rd_data_r;
  logic [AW-1:0] rd_addr;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [31:0]   wr_data;

  logic [CW-1:0] count_r;
  logic          ovf_r;
  logic [AW-1:0] hi_r;
  logic [AW-1:0] k_r;
  logic [AW-1:0] j_r;
  logic [31:0]   cur_r;
  logic [31:0]   out_value_r;
  logic          out_last_r;

  logic          full;
  logic          swap;
  logic [AW:0]   k_p1;
  logic [AW:0]   k_p2;

  assign full = (count_r == CW'(MAX_ELEMENTS));
  assign k_p1 = {1'b0, k_r} + (AW+1)'(1);
  assign k_p2 = {1'b0, k_r} + (AW+1)'(2);
  // The carried element moves right only if its neighbor is strictly smaller.
  assign swap = $signed(cur_r) > $signed(rd_data_r);

  always_comb begin
    unique case (cmd.rd_sel)
      RD_ZERO: rd_addr = '0;
      RD_K1:   rd_addr = k_p1[AW-1:0];
      RD_K2:   rd_addr = k_p2[AW-1:0];
      RD_J:    rd_addr = j_r;
      default: rd_addr = '0;
    endcase
  end

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = count_r[AW-1:0];
    wr_data = in_value;
    priority if (cmd.store_in) begin
      wr_en   = !full;
      wr_addr = count_r[AW-1:0];
      wr_data = in_value;
    end else if (cmd.step) begin
      wr_en   = 1'b1;
      wr_addr = k_r;
      wr_data = swap ? rd_data_r : cur_r;
    end else if (cmd.pass_end) begin
      wr_en   = 1'b1;
      wr_addr = hi_r;
      wr_data = cur_r;
    end else begin
      wr_en   = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      ovf_r   <= 1'b0;
    end else begin
      if (cmd.run_done) begin
        count_r <= '0;
        ovf_r   <= 1'b0;
      end else if (cmd.store_in) begin
        if (full) begin
          ovf_r <= 1'b1;
        end else begin
          count_r <= count_r + CW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.sort_init) begin
      hi_r <= AW'(count_r - CW'(1));
      j_r  <= '0;
      k_r  <= '0;
    end
    if (cmd.ld_cur) begin
      cur_r <= rd_data_r;
    end
    if (cmd.step) begin
      k_r <= k_p1[AW-1:0];
      if (!swap) begin
        cur_r <= rd_data_r;
      end
    end
    if (cmd.pass_end) begin
      hi_r <= hi_r - AW'(1);
      k_r  <= '0;
    end
    if (cmd.out_next) begin
      j_r <= j_r + AW'(1);
    end
    if (cmd.out_load) begin
      out_value_r <= rd_data_r;
      out_last_r  <= stat.j_last;
    end
  end

  assign stat.count_gt1 = (count_r > CW'(1));
  assign stat.step_last = (k_p1 == {1'b0, hi_r});
  assign stat.hi_one    = (hi_r == AW'(1));
  assign stat.j_last    = ((CW'(j_r) + CW'(1)) == count_r);

  assign out_value   = out_value_r;
  assign out_last    = out_last_r;
  assign out_dropped = ovf_r;

endmodule

FILE: rtl/core/bubble_sort_engine.sv
// Top level of the bubble sort engine: controller plus datapath.
// Signed 32-bit values arrive one per request and are stored in order of
// arrival, up to MAX_ELEMENTS of them; further values in the same set are
// discarded and every result of that run carries out_tuser = 1. The request
// with in_tlast high closes the set (its value is stored if there is room).
// The block then sorts in place with bubble passes over a one-read,
// one-write element store, carrying the larger element rightward, and
// finally sends the values in ascending order with out_tlast on the last.
// While collecting, one input request is taken per cycle. The sorting passes
// are paced by the single read and single write port of the store; each
// result is read from the store, loaded into the output register and held
// until accepted. No input is taken from the closing request until the
// last result has been accepted. Equal values keep their order of arrival.
module bubble_sort_engine
  import bse_pkg::*;
#(
  parameter int MAX_ELEMENTS = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [31:0] value
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [31:0] sorted_value
  output logic        out_tlast,
  output logic        out_tuser   // [0] dropped
);

  bse_cmd_t  cmd;
  bse_stat_t stat;

  bse_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tlast   (in_tlast),
    .in_tready  (in_tready),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .stat       (stat),
    .cmd        (cmd)
  );

  bse_dp #(
    .MAX_ELEMENTS (MAX_ELEMENTS)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .in_value    (in_tdata),
    .stat        (stat),
    .out_value   (out_tdata),
    .out_last    (out_tlast),
    .out_dropped (out_tuser)
  );

endmodule
